### sv/tss_pkg.sv
package tss_pkg;

    // command codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_UPDATE  = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_MUTE    = 2'd3
    } kind_t;

    localparam int FIFO_DEPTH_DEF = 8;

    // divider constants: top = (TICKS + f/2) / f - 1
    localparam int          DIV_W         = 20;
    localparam logic [19:0] TICKS_PER_SEC = 20'd1000000;
    localparam logic [15:0] FREQ_MIN      = 16'd20;
    localparam logic [15:0] FREQ_MAX      = 16'd20000;

    // stream widths
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // input tdata layout
    localparam int I_FREQ = 0;
    localparam int I_DUR  = 16;
    localparam int I_NOW  = 32;
    localparam int I_MUTE = 64;

    // output tdata layout
    localparam int O_ACC   = 0;
    localparam int O_BUSY  = 1;
    localparam int O_TONE  = 2;
    localparam int O_DIV   = 3;
    localparam int O_FREQ  = 19;
    localparam int O_DUR   = 35;
    localparam int O_COUNT = 51;
    localparam int O_START = 67;

endpackage

### sv/tone_step_sequencer_top.sv
// channel  | direction | tdata (low bit up)                              | tuser
// s_axis   | in        | frequency_hz 16, duration_ms 16, now_ms 32,     | kind 2
//          |           | mute_request 1, zero pad to 72                  |
// m_axis   | out       | accepted 1, busy_res 1, tone_enable 1,          | none
//          |           | divider_top 16, shown_frequency 16,             |
//          |           | shown_duration 16, change_count 16,             |
//          |           | step_started 1, zero pad to 72                  |
//
// one command at a time; the result passes from S_OUT into the output register, which
// can stall, and the next command is taken once the sequencer is back in S_IDLE
// an update that starts a step also passes through S_READ for the step memory read,
// and through S_DIV when the tone divider top is computed by the 1-bit-a-cycle divider
// reset is asynchronous, active low; the step memory itself is not cleared
// the output register holds a result while m_axis_tready is low; the next
// command is taken meanwhile and waits in its final state for the register
module tone_step_sequencer_top
    import tss_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frequency_hz, duration_ms, now_ms, mute_request, pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted, busy_res, tone_enable, divider_top, shown_frequency,
    // shown_duration, change_count, step_started, pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int ITER_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  rd_slot_reg;
    logic [PTR_W-1:0]  wr_slot_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [31:0]       end_time_reg;
    logic              running_reg;
    logic [15:0]       cur_freq_reg;
    logic [15:0]       cur_dur_reg;
    logic [15:0]       revision_reg;
    logic              mute_reg;
    logic              tone_on_reg;
    logic [15:0]       top_reg;
    logic              accepted_reg;
    logic              started_reg;
    logic [31:0]       now_reg;
    logic [15:0]       div_rem_reg;
    logic [DIV_W-1:0]  div_num_reg;
    logic [ITER_W-1:0] div_iter_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // step memory, {frequency, duration}
    logic [31:0]       step_mem [0:FIFO_DEPTH-1];
    logic [31:0]       mem_rdata_reg;

    // input fields
    kind_t       in_kind;
    logic [15:0] in_freq;
    logic [15:0] in_dur;
    logic [31:0] in_now;
    logic        in_mute;

    assign in_kind = kind_t'(s_axis_tuser);
    assign in_freq = s_axis_tdata[I_FREQ +: 16];
    assign in_dur  = s_axis_tdata[I_DUR +: 16];
    assign in_now  = s_axis_tdata[I_NOW +: 32];
    assign in_mute = s_axis_tdata[I_MUTE];

    logic in_xfer;
    logic fifo_full;
    logic mem_we;
    logic [31:0] diff;
    logic step_done;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign fifo_full     = (fill_reg == CNT_W'(FIFO_DEPTH));
    assign mem_we        = in_xfer && (in_kind == KIND_ENQUEUE) && (in_dur != 16'd0)
                           && !fifo_full;
    // wrap-safe end check: done once now - end is not negative
    assign diff          = in_now - end_time_reg;
    assign step_done     = !running_reg || !diff[31];

    // slot advance with wrap at the configured depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
        logic [PTR_W-1:0] r;
        if (slot == PTR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = slot + PTR_W'(1);
        return r;
    endfunction

    // step memory port: one write, registered read at the head slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            step_mem[wr_slot_reg] <= {in_freq, in_dur};
        end
        mem_rdata_reg <= step_mem[rd_slot_reg];
    end

    // divider step, one quotient bit a cycle
    logic [16:0]      rem_shift;
    logic             q_bit;
    logic [15:0]      rem_step;
    logic [DIV_W-1:0] quot_step;
    logic [DIV_W-1:0] quot_m1;

    assign rem_shift = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, cur_freq_reg});
    assign rem_step  = q_bit ? 16'(rem_shift - {1'b0, cur_freq_reg}) : rem_shift[15:0];
    assign quot_step = {div_num_reg[DIV_W-2:0], q_bit};
    assign quot_m1   = quot_step - DIV_W'(1);

    // result word from the state after the command
    logic [OUT_DATA_W-1:0] result;
    always_comb
    begin
        result                   = '0;
        result[O_ACC]            = accepted_reg;
        result[O_BUSY]           = running_reg || (fill_reg != '0);
        result[O_TONE]           = tone_on_reg;
        result[O_DIV +: 16]      = tone_on_reg ? top_reg : 16'd0;
        result[O_FREQ +: 16]     = cur_freq_reg;
        result[O_DUR +: 16]      = cur_dur_reg;
        result[O_COUNT +: 16]    = revision_reg;
        result[O_START]          = started_reg;
    end

    logic freq_in_range;
    assign freq_in_range = (mem_rdata_reg[31:16] >= FREQ_MIN)
                           && (mem_rdata_reg[31:16] <= FREQ_MAX);

    // command sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_slot_reg  <= '0;
            wr_slot_reg  <= '0;
            fill_reg     <= '0;
            end_time_reg <= '0;
            running_reg  <= 1'b0;
            cur_freq_reg <= '0;
            cur_dur_reg  <= '0;
            revision_reg <= '0;
            mute_reg     <= 1'b0;
            tone_on_reg  <= 1'b0;
            top_reg      <= '0;
            accepted_reg <= 1'b0;
            started_reg  <= 1'b0;
            now_reg      <= '0;
            div_rem_reg  <= '0;
            div_num_reg  <= '0;
            div_iter_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && (state_reg != S_OUT))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        accepted_reg <= 1'b0;
                        started_reg  <= 1'b0;
                        now_reg      <= in_now;
                        state_reg    <= S_OUT;
                        case (in_kind)
                            KIND_ENQUEUE:
                            begin
                                if (mem_we)
                                begin
                                    wr_slot_reg  <= next_slot(wr_slot_reg);
                                    fill_reg     <= fill_reg + CNT_W'(1);
                                    accepted_reg <= 1'b1;
                                end
                            end
                            KIND_UPDATE:
                            begin
                                if (step_done)
                                begin
                                    running_reg <= 1'b0;
                                    tone_on_reg <= 1'b0;
                                    // head entry arrives from memory next cycle
                                    if (fill_reg != '0)
                                    begin
                                        state_reg <= S_READ;
                                    end
                                end
                            end
                            KIND_STOP:
                            begin
                                tone_on_reg  <= 1'b0;
                                rd_slot_reg  <= '0;
                                wr_slot_reg  <= '0;
                                fill_reg     <= '0;
                                end_time_reg <= '0;
                                running_reg  <= 1'b0;
                                if ((cur_freq_reg != '0) || (cur_dur_reg != '0))
                                begin
                                    cur_freq_reg <= '0;
                                    cur_dur_reg  <= '0;
                                    revision_reg <= revision_reg + 16'd1;
                                end
                            end
                            default:
                            begin
                                mute_reg <= in_mute;
                                if (in_mute)
                                begin
                                    tone_on_reg <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    // pop the head step and start it
                    rd_slot_reg  <= next_slot(rd_slot_reg);
                    fill_reg     <= fill_reg - CNT_W'(1);
                    cur_freq_reg <= mem_rdata_reg[31:16];
                    cur_dur_reg  <= mem_rdata_reg[15:0];
                    revision_reg <= revision_reg + 16'd1;
                    end_time_reg <= now_reg + {16'd0, mem_rdata_reg[15:0]};
                    running_reg  <= 1'b1;
                    started_reg  <= 1'b1;
                    div_rem_reg  <= '0;
                    div_num_reg  <= TICKS_PER_SEC
                                    + {{(DIV_W-15){1'b0}}, mem_rdata_reg[31:17]};
                    div_iter_reg <= '0;
                    if (!mute_reg && freq_in_range)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        tone_on_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    div_rem_reg  <= rem_step;
                    div_num_reg  <= quot_step;
                    div_iter_reg <= div_iter_reg + ITER_W'(1);
                    if (div_iter_reg == ITER_W'(DIV_W - 1))
                    begin
                        top_reg     <= quot_m1[15:0];
                        tone_on_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // wait for the output register to be free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### sv/tss_checker.sv
module tss_port_checker
    import tss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command at a time: no second transfer right after one
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // divider top reads zero while the tone is off
    a_top_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[O_TONE] |-> m_axis_tdata[O_DIV +: 16] == 16'd0)
        else $error("divider top shown with tone off");

    // a started step leaves the sequencer busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[O_START] |-> m_axis_tdata[O_BUSY])
        else $error("step started but not busy");

    // an enqueue never also starts a step
    a_acc_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[O_ACC] && m_axis_tdata[O_START]))
        else $error("accepted and started together");

endmodule

bind tone_step_sequencer_top tss_port_checker u_tss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
